@@ rtl/core/spl_pkg.sv @@
`default_nettype none

package spl_pkg;

	localparam int MAX_PAYLOAD_DEF = 32;
	localparam int BURST_MAX       = 6;
	localparam int BURST_CNT_W     = $clog2(BURST_MAX + 1);
	localparam int CFG_IDX_W       = 2;

	localparam logic [7:0] PREAMBLE = 8'hFF;

	localparam logic CMD_TX = 1'b0;
	localparam logic CMD_RX = 1'b1;

	localparam logic [1:0] KIND_LINE     = 2'd0;
	localparam logic [1:0] KIND_GOOD     = 2'd1;
	localparam logic [1:0] KIND_CSUM_ERR = 2'd2;
	localparam logic [1:0] KIND_TIMEOUT  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_SERVO_ID       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPLY_EXPECTED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS   = 2'd2;

	localparam logic [7:0] RST_SERVO_ID     = 8'd1;
	localparam logic [7:0] RST_MAX_ATTEMPTS = 8'd10;

	typedef struct packed {
		logic [7:0] servo_id;
		logic       reply_expected;
		logic [7:0] max_attempts;
	} cfg_t;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
		logic [5:0] payload_length;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tx_byte;
		logic [7:0]  status;
		logic [15:0] value;
	} result_t;

	typedef struct packed {
		logic [BURST_CNT_W-1:0]         cnt;
		result_t [BURST_MAX-1:0]        ent;
	} burst_t;

endpackage

`default_nettype wire

@@ rtl/core/servo_packet_link_engine.sv @@
// An accepted item is registered in the input stage, then loaded with its
//   results into the output register once that register is free.
// Throughput: one input item per cycle unless in_stall; the output register
//   sends one beat per cycle unless out_stall; input waits for the last beat.
// Reset (arst_n low): transmit and receive state cleared, registers back to
//   servo_id 1, reply_expected 0, max_attempts 10; no beats pending.
`default_nettype none

module servo_packet_link_engine #(
	parameter int MAX_PAYLOAD = spl_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [spl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                    cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          command,
	input  wire logic [7:0]                    data_byte,
	input  wire logic [5:0]                    payload_length,
	input  wire logic                          last_byte,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [1:0]                         out_kind,
	output logic [7:0]                         tx_byte,
	output logic [7:0]                         reply_status,
	output logic [15:0]                        reply_value,
	output logic                               run_end
);

	spl_pkg::cfg_t    cfg_q;
	spl_pkg::item_t   item_s1;
	logic             valid_s1;
	logic             free;
	logic             load;
	spl_pkg::burst_t  burst;
	spl_pkg::result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.servo_id <= spl_pkg::RST_SERVO_ID;
			cfg_q.reply_expected <= 1'b0;
			cfg_q.max_attempts <= spl_pkg::RST_MAX_ATTEMPTS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spl_pkg::CFG_SERVO_ID:       cfg_q.servo_id <= cfg_data;
				spl_pkg::CFG_REPLY_EXPECTED: cfg_q.reply_expected <= cfg_data[0];
				spl_pkg::CFG_MAX_ATTEMPTS:   cfg_q.max_attempts <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign load = valid_s1 && free;
	assign in_stall = valid_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1.command <= command;
			item_s1.data_byte <= data_byte;
			item_s1.payload_length <= payload_length;
			item_s1.last_byte <= last_byte;
		end
	end

	spl_core #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (load),
		.item  (item_s1),
		.cfg   (cfg_q),
		.burst (burst)
	);

	spl_burst u_burst (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.burst    (burst),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.free     (free),
		.res      (res),
		.run_end  (run_end)
	);

	assign out_kind = res.kind;
	assign tx_byte = res.tx_byte;
	assign reply_status = res.status;
	assign reply_value = res.value;

endmodule

`default_nettype wire

@@ rtl/core/spl_core.sv @@
`default_nettype none

module spl_core #(
	parameter int MAX_PAYLOAD = spl_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           fire,
	input  wire spl_pkg::item_t item,
	input  wire spl_pkg::cfg_t  cfg,
	output spl_pkg::burst_t     burst
);

	localparam int REM_W = $clog2(MAX_PAYLOAD + 1);
	localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);
	localparam logic [8:0] MAX_LEN_BYTE = 9'(MAX_PAYLOAD + 1);

	localparam logic [2:0] PH_HUNT1 = 3'd0;
	localparam logic [2:0] PH_HUNT2 = 3'd1;
	localparam logic [2:0] PH_ID    = 3'd2;
	localparam logic [2:0] PH_LEN   = 3'd3;
	localparam logic [2:0] PH_BODY  = 3'd4;
	localparam logic [2:0] PH_SUM   = 3'd5;
	localparam logic [2:0] PH_IDLE  = 3'd6;

	logic             tx_in_packet_q, tx_in_packet_d;
	logic [7:0]       tx_sum_q, tx_sum_d;
	logic [2:0]       phase_q, phase_d;
	logic [REM_W-1:0] rem_q, rem_d;
	logic [7:0]       rx_sum_q, rx_sum_d;
	logic [1:0]       idx_q, idx_d;
	logic [7:0]       status_q, status_d;
	logic [15:0]      value_q, value_d;
	logic [7:0]       dc_q, dc_d;

	logic [7:0] plen8, len_n, lenb, tx_base, tx_sum_nx, dc_inc, b;
	logic       disc, disc_keep_id, timeout;

	function automatic spl_pkg::result_t line_res(input logic [7:0] v);
		spl_pkg::result_t r;
		r = '0;
		r.kind = spl_pkg::KIND_LINE;
		r.tx_byte = v;
		return r;
	endfunction

	always_comb begin
		b = item.data_byte;
		tx_in_packet_d = tx_in_packet_q;
		tx_sum_d = tx_sum_q;
		phase_d = phase_q;
		rem_d = rem_q;
		rx_sum_d = rx_sum_q;
		idx_d = idx_q;
		status_d = status_q;
		value_d = value_q;
		dc_d = dc_q;
		burst = '0;
		disc = 1'b0;
		disc_keep_id = 1'b0;

		plen8 = {2'b00, item.payload_length};
		if (plen8 == 8'd0) begin
			len_n = 8'd1;
		end else if (plen8 > MAX_LEN) begin
			len_n = MAX_LEN;
		end else begin
			len_n = plen8;
		end
		lenb = 8'(len_n + 8'd1);
		tx_base = tx_in_packet_q ? tx_sum_q : 8'(cfg.servo_id + lenb);
		tx_sum_nx = 8'(tx_base + b);

		dc_inc = (dc_q != 8'hFF) ? 8'(dc_q + 8'd1) : dc_q;
		timeout = (dc_inc >= cfg.max_attempts);

		if (item.command == spl_pkg::CMD_TX) begin
			if (!tx_in_packet_q) begin
				burst.ent[0] = line_res(spl_pkg::PREAMBLE);
				burst.ent[1] = line_res(spl_pkg::PREAMBLE);
				burst.ent[2] = line_res(cfg.servo_id);
				burst.ent[3] = line_res(lenb);
				burst.ent[4] = line_res(b);
				burst.ent[5] = line_res(~tx_sum_nx);
				burst.cnt = item.last_byte ? spl_pkg::BURST_CNT_W'(6) : spl_pkg::BURST_CNT_W'(5);
			end else begin
				burst.ent[0] = line_res(b);
				burst.ent[1] = line_res(~tx_sum_nx);
				burst.cnt = item.last_byte ? spl_pkg::BURST_CNT_W'(2) : spl_pkg::BURST_CNT_W'(1);
			end
			if (item.last_byte) begin
				tx_in_packet_d = 1'b0;
				tx_sum_d = 8'd0;
				if (cfg.reply_expected) begin
					phase_d = PH_HUNT1;
					rem_d = '0;
					rx_sum_d = 8'd0;
					idx_d = 2'd0;
					status_d = 8'd0;
					value_d = 16'd0;
					dc_d = 8'd0;
				end
			end else begin
				tx_in_packet_d = 1'b1;
				tx_sum_d = tx_sum_nx;
			end
		end else if (cfg.reply_expected) begin
			unique case (phase_q)
				PH_HUNT1: begin
					if (b == spl_pkg::PREAMBLE) phase_d = PH_HUNT2;
					else disc = 1'b1;
				end
				PH_HUNT2: begin
					if (b == spl_pkg::PREAMBLE) phase_d = PH_ID;
					else disc = 1'b1;
				end
				PH_ID: begin
					if (b == cfg.servo_id) begin
						phase_d = PH_LEN;
					end else begin
						disc = 1'b1;
						// An extra preamble byte keeps us waiting for the id, unless it times out.
						disc_keep_id = (b == spl_pkg::PREAMBLE);
					end
				end
				PH_LEN: begin
					if (b == 8'd0 || {1'b0, b} > MAX_LEN_BYTE) begin
						disc = 1'b1;
					end else begin
						rx_sum_d = 8'(cfg.servo_id + b);
						rem_d = REM_W'(b - 8'd1);
						idx_d = 2'd0;
						status_d = 8'd0;
						value_d = 16'd0;
						phase_d = (b == 8'd1) ? PH_SUM : PH_BODY;
					end
				end
				PH_BODY: begin
					if (idx_q == 2'd0) status_d = b;
					else if (idx_q == 2'd1) value_d = {value_q[15:8], b};
					else if (idx_q == 2'd2) value_d = {b, value_q[7:0]};
					if (idx_q != 2'd3) idx_d = 2'(idx_q + 2'd1);
					rx_sum_d = 8'(rx_sum_q + b);
					rem_d = REM_W'(rem_q - REM_W'(1));
					if (rem_q == REM_W'(1)) phase_d = PH_SUM;
				end
				PH_SUM: begin
					burst.cnt = spl_pkg::BURST_CNT_W'(1);
					if (b == ~rx_sum_q) begin
						burst.ent[0].kind = spl_pkg::KIND_GOOD;
						burst.ent[0].status = status_q;
						burst.ent[0].value = value_q;
					end else begin
						burst.ent[0].kind = spl_pkg::KIND_CSUM_ERR;
					end
					phase_d = PH_IDLE;
				end
				default: begin
				end
			endcase
			if (disc) begin
				dc_d = dc_inc;
				if (timeout) begin
					phase_d = PH_IDLE;
					burst.cnt = spl_pkg::BURST_CNT_W'(1);
					burst.ent[0].kind = spl_pkg::KIND_TIMEOUT;
				end else begin
					phase_d = disc_keep_id ? PH_ID : PH_HUNT1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_in_packet_q <= 1'b0;
			tx_sum_q <= 8'd0;
			phase_q <= PH_HUNT1;
			rem_q <= '0;
			rx_sum_q <= 8'd0;
			idx_q <= 2'd0;
			status_q <= 8'd0;
			value_q <= 16'd0;
			dc_q <= 8'd0;
		end else if (fire) begin
			tx_in_packet_q <= tx_in_packet_d;
			tx_sum_q <= tx_sum_d;
			phase_q <= phase_d;
			rem_q <= rem_d;
			rx_sum_q <= rx_sum_d;
			idx_q <= idx_d;
			status_q <= status_d;
			value_q <= value_d;
			dc_q <= dc_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/spl_burst.sv @@
`default_nettype none

module spl_burst (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire spl_pkg::burst_t burst,
	input  wire logic            out_stall,
	output logic                 out_valid,
	output logic                 free,
	output spl_pkg::result_t     res,
	output logic                 run_end
);

	spl_pkg::result_t [spl_pkg::BURST_MAX-1:0] ent_q;
	logic [spl_pkg::BURST_CNT_W-1:0]           cnt_q;
	logic                                      take;

	assign out_valid = (cnt_q != '0);
	assign take = out_valid && !out_stall;
	// A new burst may replace the last beat in the cycle that beat leaves.
	assign free = (cnt_q == '0) || (cnt_q == spl_pkg::BURST_CNT_W'(1) && !out_stall);
	assign res = ent_q[0];
	assign run_end = (cnt_q == spl_pkg::BURST_CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= burst.cnt;
		end else if (take) begin
			cnt_q <= spl_pkg::BURST_CNT_W'(cnt_q - spl_pkg::BURST_CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= burst.ent;
		end else if (take) begin
			for (int i = 0; i < spl_pkg::BURST_MAX - 1; i++) begin
				ent_q[i] <= ent_q[i+1];
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/spl_checker.sv @@
`default_nettype none

module spl_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  out_kind,
	input wire logic [7:0]  tx_byte,
	input wire logic [7:0]  reply_status,
	input wire logic [15:0] reply_value,
	input wire logic        run_end
);

	// Replies, checksum errors and timeouts each stand alone as one beat.
	a_report_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_kind != spl_pkg::KIND_LINE) |-> (run_end && tx_byte == 8'd0))
		else $error("report beat not alone or carries a line byte");

	a_line_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_kind == spl_pkg::KIND_LINE) |->
		(reply_status == 8'd0 && reply_value == 16'd0))
		else $error("line beat carries reply fields");

	// A burst that is not finished keeps going in the next cycle.
	a_burst_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !run_end) |=> out_valid)
		else $error("burst broke off before its last beat");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_kind) && $stable(tx_byte)))
		else $error("stalled output beat changed");

endmodule

bind servo_packet_link_engine spl_checker u_spl_checker (.*);

`default_nettype wire
